// ===== hdl/tilt_complementary_fir_filter_top_assert.svh =====
// assertion macros for the tilt filter top level
// expects clk and rst_n in the scope of use
`ifndef TILT_COMPLEMENTARY_FIR_FILTER_TOP_ASSERT_SVH
`define TILT_COMPLEMENTARY_FIR_FILTER_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define TCF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define TCF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/tcf_pkg.sv =====
// shared types, constants and fixed-point helpers for the tilt filter
// no dependencies
package tcf_pkg;

  localparam int ANGLE_W   = 16;
  localparam int GAIN_W    = 16;
  localparam int COEF_W    = GAIN_W + 2;
  localparam int PROD_W    = COEF_W + ANGLE_W;
  localparam int ACC_W     = PROD_W + 2;
  localparam int TAP_COUNT = 10;
  localparam int HIST_D    = TAP_COUNT - 1;
  localparam int TAP_W     = $clog2(TAP_COUNT);
  localparam int HIST_W    = $clog2(HIST_D);
  localparam int CFG_IDX_W = 2;

  typedef logic signed [ANGLE_W-1:0] angle_t;
  typedef logic        [GAIN_W-1:0]  gain_t;
  typedef logic signed [COEF_W-1:0]  coef_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [ACC_W-1:0]   acc_t;
  typedef logic        [TAP_W-1:0]   tap_idx_t;
  typedef logic        [HIST_W-1:0]  hist_idx_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLEND_GAIN   = 2'd0,
    REG_CORR_GAIN    = 2'd1,
    REG_TIME_STEP    = 2'd2,
    REG_FILTER_ORDER = 2'd3
  } reg_idx_t;

  localparam gain_t RST_BLEND_GAIN = 16'd64225;
  localparam gain_t RST_CORR_GAIN  = 16'd256;
  localparam gain_t RST_TIME_STEP  = 16'd328;

  localparam coef_t ONE_Q16 = 18'sd65536;

  localparam gain_t FIR_COEF [TAP_COUNT] = '{
    16'd442, 16'd1643, 16'd5368, 16'd10679, 16'd14636,
    16'd14636, 16'd10679, 16'd5368, 16'd1643, 16'd442
  };

  localparam logic signed [ACC_W:0] RND_Q8  = (ACC_W+1)'(128);
  localparam logic signed [ACC_W:0] RND_Q16 = (ACC_W+1)'(32768);

  typedef struct packed {
    gain_t blend_gain;
    gain_t correction_gain;
    gain_t time_step;
    logic  filter_order;
  } cfg_t;

  typedef struct packed {
    logic   en;
    logic   clr;
    coef_t  coef;
    angle_t data;
  } mac_op_t;

  function automatic coef_t gain_coef(gain_t g);
    return signed'({2'b00, g});
  endfunction

  // saturating add or subtract of two angles
  function automatic angle_t sat_add(angle_t a, angle_t b, logic sub);
    logic signed [ANGLE_W:0] s;
    s = sub ? ({a[ANGLE_W-1], a} - {b[ANGLE_W-1], b})
            : ({a[ANGLE_W-1], a} + {b[ANGLE_W-1], b});
    if (s[ANGLE_W] != s[ANGLE_W-1]) begin
      return {s[ANGLE_W], {(ANGLE_W-1){~s[ANGLE_W]}}};
    end
    return s[ANGLE_W-1:0];
  endfunction

  // round half up by 2^8 or 2^16, then saturate to an angle
  function automatic angle_t rnd_sat(acc_t acc, logic q16);
    logic signed [ACC_W:0] w;
    logic signed [ACC_W:0] sh;
    w  = {acc[ACC_W-1], acc} + (q16 ? RND_Q16 : RND_Q8);
    sh = q16 ? (w >>> 16) : (w >>> 8);
    if (!((&sh[ACC_W:ANGLE_W-1]) || (~|sh[ACC_W:ANGLE_W-1]))) begin
      return {sh[ACC_W], {(ANGLE_W-1){~sh[ACC_W]}}};
    end
    return sh[ANGLE_W-1:0];
  endfunction

endpackage

// ===== hdl/tcf_if.sv =====
// valid/ready channel interfaces for sample and result transactions
// depends on tcf_pkg
interface tcf_in_if;
  logic            valid;
  logic            ready;
  tcf_pkg::angle_t accel_angle_x;
  tcf_pkg::angle_t rate_about_y;
  tcf_pkg::angle_t accel_angle_y;
  tcf_pkg::angle_t rate_about_x;

  modport source (
    output valid, accel_angle_x, rate_about_y, accel_angle_y, rate_about_x,
    input  ready
  );
  modport sink (
    input  valid, accel_angle_x, rate_about_y, accel_angle_y, rate_about_x,
    output ready
  );
endinterface

interface tcf_out_if;
  logic            valid;
  logic            ready;
  tcf_pkg::angle_t tilt_x;
  tcf_pkg::angle_t tilt_y;

  modport source (
    output valid, tilt_x, tilt_y,
    input  ready
  );
  modport sink (
    input  valid, tilt_x, tilt_y,
    output ready
  );
endinterface

// ===== hdl/tilt_complementary_fir_filter_top.sv =====
// Two-axis tilt filter: complementary blend (first or second order) then a
// 10-tap symmetric FIR low-pass per axis, fixed point, 1/128 degree angles.
// in_ch carries one sample transaction: accel angle and gyro rate for x and y.
// out_ch carries one result transaction: tilt_x and tilt_y.
// cfg_we/cfg_index/cfg_wdata write blend_gain, correction_gain, time_step and
// filter_order; write only while no sample is in flight.
// Each sample is worked through in steps on the single multiply-accumulate unit:
// per axis one product per step (error gain in second order only, rate times
// step, two blend terms, ten FIR taps) plus result and rounding steps, x axis
// then y. The next sample is accepted only once the previous result has moved
// on to the output register.
// in_ch.ready is high only while idle; a new sample is accepted while the
// previous result still waits in the output register. If out_ch is stalled
// when the next result is done, the sequencer holds it until the register frees.
// Synchronous active-low reset clears the blend state, FIR history, output
// valid and loads the register defaults.
// depends on tcf_pkg, tcf_if, tcf_mac, tcf_seq and the assertion header
module tilt_complementary_fir_filter_top (
  input  logic                              clk,
  input  logic                              rst_n,
  tcf_in_if.sink                            in_ch,
  tcf_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [tcf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tcf_pkg::GAIN_W-1:0]        cfg_wdata
);

  `include "tilt_complementary_fir_filter_top_assert.svh"

  tcf_pkg::cfg_t    cfg_r;
  tcf_pkg::mac_op_t mac_op;
  tcf_pkg::acc_t    acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.blend_gain      <= tcf_pkg::RST_BLEND_GAIN;
      cfg_r.correction_gain <= tcf_pkg::RST_CORR_GAIN;
      cfg_r.time_step       <= tcf_pkg::RST_TIME_STEP;
      cfg_r.filter_order    <= 1'b0;
    end else if (cfg_we) begin
      case (tcf_pkg::reg_idx_t'(cfg_index))
        tcf_pkg::REG_BLEND_GAIN:   cfg_r.blend_gain      <= cfg_wdata;
        tcf_pkg::REG_CORR_GAIN:    cfg_r.correction_gain <= cfg_wdata;
        tcf_pkg::REG_TIME_STEP:    cfg_r.time_step       <= cfg_wdata;
        tcf_pkg::REG_FILTER_ORDER: cfg_r.filter_order    <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  tcf_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .mac_op (mac_op),
    .acc    (acc)
  );

  tcf_mac u_mac (
    .clk (clk),
    .op  (mac_op),
    .acc (acc)
  );

  `TCF_ASSERT_NEXT(a_busy_after_accept, in_ch.valid && in_ch.ready, !in_ch.ready,
                   "sequencer ready right after accepting a transaction")
  `TCF_ASSERT_NOW(a_result_from_work, $rose(out_ch.valid), $past(!in_ch.ready),
                  "result raised while sequencer was idle")
  `TCF_ASSERT_NEXT(a_result_held_on_accept, in_ch.valid && in_ch.ready,
                   $stable(out_ch.tilt_x) && $stable(out_ch.tilt_y),
                   "output register changed on input accept")

endmodule

// ===== hdl/tcf_mac.sv =====
// shared multiply-accumulate unit, one product per cycle into the accumulator while op.en is set
// depends on tcf_pkg
module tcf_mac (
  input  logic             clk,
  input  tcf_pkg::mac_op_t op,
  output tcf_pkg::acc_t    acc
);

  tcf_pkg::acc_t  acc_r;
  tcf_pkg::acc_t  acc_nxt;
  tcf_pkg::prod_t prod;

  always_comb begin
    prod    = op.coef * op.data;
    acc_nxt = (op.clr ? '0 : acc_r) + tcf_pkg::ACC_W'(prod);
  end

  always_ff @(posedge clk) begin
    if (op.en) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

// ===== hdl/tcf_seq.sv =====
// sequencer: blend and fir steps for both axes on the shared mac, state and result register
// depends on tcf_pkg, tcf_if and the accumulator of tcf_mac
module tcf_seq (
  input  logic             clk,
  input  logic             rst_n,
  input  tcf_pkg::cfg_t    cfg,
  tcf_in_if.sink           in_ch,
  tcf_out_if.source        out_ch,
  output tcf_pkg::mac_op_t mac_op,
  input  tcf_pkg::acc_t    acc
);

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_CORR = 9'b000000010,
    ST_RATE = 9'b000000100,
    ST_PRED = 9'b000001000,
    ST_BLND = 9'b000010000,
    ST_BSTO = 9'b000100000,
    ST_FIR  = 9'b001000000,
    ST_FOUT = 9'b010000000,
    ST_DONE = 9'b100000000
  } state_t;

  state_t            state_r;
  state_t            state_nxt;
  state_t            axis_start;
  logic              axis_r;
  tcf_pkg::tap_idx_t tap_r;
  tcf_pkg::angle_t   ax_r, rx_r, ay_r, ry_r;
  tcf_pkg::angle_t   prev_r [2];
  tcf_pkg::angle_t   hist_r [2][tcf_pkg::HIST_D];
  tcf_pkg::angle_t   pred_r;
  tcf_pkg::angle_t   blend_r;
  tcf_pkg::angle_t   res_x_r, res_y_r;
  logic              out_valid_r;
  tcf_pkg::angle_t   out_x_r, out_y_r;

  tcf_pkg::angle_t   accel, rate, prev, err, rate_eff, pred, rounded, tap_val;
  tcf_pkg::hist_idx_t hidx;
  logic              out_free;

  always_comb begin
    accel      = axis_r ? ay_r : ax_r;
    rate       = axis_r ? ry_r : rx_r;
    prev       = prev_r[axis_r];
    err        = tcf_pkg::sat_add(accel, prev, 1'b1);
    rate_eff   = cfg.filter_order
               ? tcf_pkg::sat_add(rate, tcf_pkg::rnd_sat(acc, 1'b0), 1'b0) : rate;
    rounded    = tcf_pkg::rnd_sat(acc, 1'b1);
    pred       = tcf_pkg::sat_add(prev, rounded, 1'b0);
    hidx       = (tap_r == '0) ? '0 : tcf_pkg::HIST_W'(tap_r - 1'b1);
    tap_val    = (tap_r == '0) ? blend_r : hist_r[axis_r][hidx];
    axis_start = cfg.filter_order ? ST_CORR : ST_RATE;
    out_free   = !out_valid_r || out_ch.ready;
  end

  always_comb begin
    mac_op = '0;
    case (state_r)
      ST_CORR: begin
        mac_op = '{en: 1'b1, clr: 1'b1,
                   coef: tcf_pkg::gain_coef(cfg.correction_gain), data: err};
      end
      ST_RATE: begin
        mac_op = '{en: 1'b1, clr: 1'b1,
                   coef: tcf_pkg::gain_coef(cfg.time_step), data: rate_eff};
      end
      ST_PRED: begin
        mac_op = '{en: 1'b1, clr: 1'b1,
                   coef: tcf_pkg::ONE_Q16 - tcf_pkg::gain_coef(cfg.blend_gain),
                   data: accel};
      end
      ST_BLND: begin
        mac_op = '{en: 1'b1, clr: 1'b0,
                   coef: tcf_pkg::gain_coef(cfg.blend_gain), data: pred_r};
      end
      ST_FIR: begin
        mac_op = '{en: 1'b1, clr: (tap_r == '0),
                   coef: tcf_pkg::gain_coef(tcf_pkg::FIR_COEF[tap_r]), data: tap_val};
      end
      default: begin
        mac_op = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_ch.valid) state_nxt = axis_start;
      ST_CORR: state_nxt = ST_RATE;
      ST_RATE: state_nxt = ST_PRED;
      ST_PRED: state_nxt = ST_BLND;
      ST_BLND: state_nxt = ST_BSTO;
      ST_BSTO: state_nxt = ST_FIR;
      ST_FIR:  if (tap_r == tcf_pkg::tap_idx_t'(tcf_pkg::TAP_COUNT - 1)) state_nxt = ST_FOUT;
      ST_FOUT: state_nxt = axis_r ? ST_DONE : axis_start;
      ST_DONE: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control and filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      axis_r      <= 1'b0;
      tap_r       <= '0;
      out_valid_r <= 1'b0;
      for (int a = 0; a < 2; a++) begin
        prev_r[a] <= '0;
        for (int i = 0; i < tcf_pkg::HIST_D; i++) begin
          hist_r[a][i] <= '0;
        end
      end
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          axis_r <= 1'b0;
        end
        ST_BSTO: begin
          prev_r[axis_r] <= rounded;
          tap_r          <= '0;
        end
        ST_FIR: begin
          tap_r <= tap_r + 1'b1;
        end
        ST_FOUT: begin
          for (int i = tcf_pkg::HIST_D - 1; i > 0; i--) begin
            hist_r[axis_r][i] <= hist_r[axis_r][i-1];
          end
          hist_r[axis_r][0] <= blend_r;
          axis_r            <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_ch.valid) begin
      ax_r <= in_ch.accel_angle_x;
      rx_r <= in_ch.rate_about_y;
      ay_r <= in_ch.accel_angle_y;
      ry_r <= in_ch.rate_about_x;
    end
    if (state_r == ST_PRED) begin
      pred_r <= pred;
    end
    if (state_r == ST_BSTO) begin
      blend_r <= rounded;
    end
    if (state_r == ST_FOUT) begin
      if (axis_r) begin
        res_y_r <= rounded;
      end else begin
        res_x_r <= rounded;
      end
    end
    if (!rst_n) begin
      out_x_r <= '0;
      out_y_r <= '0;
    end else if (state_r == ST_DONE && out_free) begin
      out_x_r <= res_x_r;
      out_y_r <= res_y_r;
    end
  end

  assign in_ch.ready   = (state_r == ST_IDLE);
  assign out_ch.valid  = out_valid_r;
  assign out_ch.tilt_x = out_x_r;
  assign out_ch.tilt_y = out_y_r;

endmodule
